// File: src/magazine_slab_allocator_macros.svh
// Assertion macros used by the checker.
`ifndef MAGAZINE_SLAB_ALLOCATOR_MACROS_SVH
`define MAGAZINE_SLAB_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/msa_pkg.sv
// Shared types and constants for the magazine slab allocator.
package msa_pkg;
  localparam int HandleW = 12;
  localparam int CountW  = 13;
  localparam int SlabW   = 5;
  localparam int TotalW  = 64;
  localparam int CpuW    = 3;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic CfgObjectsPerSlab = 1'b0;
  localparam logic CfgSlabLimit      = 1'b1;

  localparam logic [CountW-1:0] CountMax = 13'd8191;
  localparam logic [11:0] SlabObjMin = 12'd2;
  localparam logic [11:0] SlabObjMax = 12'd2048;

  typedef struct packed {
    logic               operation;
    logic [CpuW-1:0]    cpu_id;
    logic [HandleW-1:0] object_handle;
  } in_word_t;

  typedef struct packed {
    logic [HandleW-1:0] granted_handle;
    logic               status;
    logic               from_magazine;
    logic [CountW-1:0]  live_count;
    logic [CountW-1:0]  idle_count;
    logic [SlabW-1:0]   slab_count;
    logic [TotalW-1:0]  alloc_total;
    logic [TotalW-1:0]  free_total;
    logic [TotalW-1:0]  fast_alloc_total;
    logic [TotalW-1:0]  fast_free_total;
  } out_word_t;

  typedef struct packed {
    logic        index;
    logic [11:0] data;
  } cfg_word_t;

  function automatic logic [TotalW-1:0] sat_inc64(input logic [TotalW-1:0] v);
    return (&v) ? v : v + 64'd1;
  endfunction
endpackage

// File: src/msa_stream_if.sv
// Valid/ready channel interface carrying one payload word.
interface msa_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/msa_mem.sv
// Single-port memory with registered read data.
module msa_mem #(
  parameter int Depth = 128,
  parameter int Width = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: src/magazine_slab_allocator.sv
// Top level: sequencer moving handles between magazine and list memories.
//
// Channel | Direction | Word
// in_     | sink      | operation, cpu_id, object_handle
// out_    | source    | granted handle, status and all totals
// cfg_    | sink      | register index, write data
//
// From accept to result: a fast free passes S_DECIDE, S_HEAD and S_RESP, a fast
// allocate S_DECIDE, S_MREAD, S_FINISH and S_RESP, and one that finds no memory
// S_DECIDE and S_RESP. A slow allocate moves up to MAGAZINE_DEPTH/2 handles into
// the magazine, one per cycle through a one-stage read/write pipeline; a free to a
// full magazine drains MAGAZINE_DEPTH/2 handles onto the list.
// The next word is taken in the cycle after the result leaves; a stalled result holds
// the block. rst_n is synchronous; memories are not cleared and no clearing pass runs.
module magazine_slab_allocator #(
  parameter int NUM_CPUS       = 8,
  parameter int MAGAZINE_DEPTH = 16,
  parameter int MAX_OBJECTS    = 4096,
  parameter int MAX_SLABS      = 16
) (
  input logic clk,
  input logic rst_n,
  msa_stream_if.sink   in_ch,
  msa_stream_if.source out_ch,
  msa_stream_if.sink   cfg_ch
);
  import msa_pkg::*;

  localparam int MagW   = $clog2(MAGAZINE_DEPTH);
  localparam int CpuIdW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int MAddrW = $clog2(NUM_CPUS * MAGAZINE_DEPTH);
  localparam int LAddrW = $clog2(MAX_OBJECTS);
  localparam int FillW  = MagW + 1;
  localparam int DepW   = LAddrW + 1;
  localparam int Batch  = MAGAZINE_DEPTH / 2;
  localparam int BatchW = $clog2(Batch + 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DECIDE  = 10'b0000000010,
    S_MREAD   = 10'b0000000100,
    S_LREAD   = 10'b0000001000,
    S_REFILL  = 10'b0000010000,
    S_DRAIN   = 10'b0000100000,
    S_DRAINW  = 10'b0001000000,
    S_FINISH  = 10'b0010000000,
    S_RESP    = 10'b0100000000,
    S_HEAD    = 10'b1000000000
  } state_t;

  state_t state_r;

  logic [11:0] ops_r;
  logic [4:0]  lim_r;
  logic [FillW-1:0] fill_r [NUM_CPUS];

  logic [DepW-1:0]   depth_r;
  logic [DepW:0]     cnext_r, cend_r;
  logic [SlabW-1:0]  slabs_r;
  logic [CountW-1:0] live_r, idle_r;
  logic [TotalW-1:0] atot_r, ftot_r, fatot_r, fftot_r;

  in_word_t          req_r;
  logic [HandleW-1:0] grant_r;
  logic status_r, fast_r, refill_r;
  logic [BatchW-1:0] cnt_r, n_r;
  logic [FillW-1:0]  base_r;
  logic              rd_pend_r;
  logic              rd_src_list_r;
  logic              wr_pend_r;
  logic [HandleW-1:0] wr_data_r;
  out_word_t         out_r;
  logic              out_v_r;

  // Memories.
  logic              m_we, l_we;
  logic [MAddrW-1:0] m_addr;
  logic [LAddrW-1:0] l_addr;
  logic [HandleW-1:0] m_wdata, l_wdata, m_rdata, l_rdata;

  msa_mem #(.Depth(NUM_CPUS * MAGAZINE_DEPTH), .Width(HandleW)) u_mag (
    .clk, .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
  msa_mem #(.Depth(MAX_OBJECTS), .Width(HandleW)) u_list (
    .clk, .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));

  logic has_mag;
  logic [CpuIdW-1:0] cpu;
  logic [FillW-1:0] fill;
  logic [12:0] ops_c;
  logic [4:0]  lim_c;
  logic list_empty;
  logic list_room;
  logic [MAddrW-1:0] mag_base;

  assign has_mag = ({29'd0, req_r.cpu_id} < NUM_CPUS);
  assign cpu     = has_mag ? CpuIdW'(req_r.cpu_id) : '0;
  assign fill    = fill_r[cpu];
  assign ops_c   = (ops_r < SlabObjMin) ? 13'(SlabObjMin) :
                   (ops_r > SlabObjMax) ? 13'(SlabObjMax) : {1'b0, ops_r};
  assign lim_c   = ({27'd0, lim_r} > MAX_SLABS) ? 5'(MAX_SLABS) : lim_r;
  assign list_empty = (depth_r == '0) && (cnext_r >= cend_r);
  // A push onto a full list is dropped.
  assign list_room = (depth_r < DepW'(MAX_OBJECTS));
  assign mag_base = MAddrW'(cpu) * MAddrW'(MAGAZINE_DEPTH);

  assign in_ch.ready  = (state_r == S_IDLE) && !out_v_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // Shared move unit: list pop helper signals.
  logic pop_stack;
  assign pop_stack = (depth_r != '0);

  logic [BatchW-1:0] room_batch, refill_n;
  always_comb begin
    logic [FillW:0] room;
    logic [DepW:0]  avail;
    room = (FillW+1)'(MAGAZINE_DEPTH) - {1'b0, fill};
    room_batch = (room < (FillW+1)'(Batch)) ? BatchW'(room) : BatchW'(Batch);
    // Entries left on the list once the head has been taken.
    avail = (DepW+1)'(depth_r) + cend_r - cnext_r - (DepW+1)'(1);
    refill_n = (avail < (DepW+1)'(room_batch)) ? BatchW'(avail) : room_batch;
  end

  // Memory ports. The read data of a memory is registered and arrives in the cycle after its address.
  always_comb begin
    m_we = 1'b0;
    l_we = 1'b0;
    m_addr = mag_base;
    l_addr = LAddrW'(depth_r);
    m_wdata = wr_data_r;
    l_wdata = wr_data_r;
    unique case (state_r)
      S_HEAD: begin
        m_addr = mag_base + MAddrW'(fill);
        m_we = 1'b1;
      end
      S_MREAD: m_addr = mag_base + MAddrW'(fill);
      S_REFILL: begin
        // The entry popped k-th lands at base + n - 1 - k, so the next list
        // entry ends on top of the magazine.
        l_addr = LAddrW'(depth_r - 1'b1);
        m_addr = mag_base + MAddrW'(base_r) + MAddrW'(n_r) - MAddrW'(cnt_r);
        m_we = wr_pend_r;
        m_wdata = rd_src_list_r ? l_rdata : wr_data_r;
      end
      S_DRAINW: l_we = list_room;
      S_DRAIN: begin
        m_addr = mag_base + MAddrW'(base_r) + MAddrW'(cnt_r);
        l_we = wr_pend_r && list_room;
        l_wdata = m_rdata;
      end
      S_IDLE, S_DECIDE, S_LREAD, S_FINISH, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ops_r <= 12'd64;
      lim_r <= 5'd16;
      for (int i = 0; i < NUM_CPUS; i++) fill_r[i] <= '0;
      depth_r <= '0; cnext_r <= '0; cend_r <= '0; slabs_r <= '0;
      live_r <= '0; idle_r <= '0;
      atot_r <= '0; ftot_r <= '0; fatot_r <= '0; fftot_r <= '0;
      out_v_r <= 1'b0;
      wr_pend_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.data.index == CfgObjectsPerSlab) ops_r <= cfg_ch.data.data;
        else lim_r <= cfg_ch.data.data[4:0];
      end
      if (state_r == S_RESP) out_v_r <= 1'b1;
      else if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          req_r <= in_ch.data;
          grant_r <= '0; status_r <= 1'b0; fast_r <= 1'b0; refill_r <= 1'b0;
          wr_pend_r <= 1'b0;
          rd_pend_r <= 1'b0;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (req_r.operation == OpFree) begin
            live_r <= (live_r == '0) ? '0 : live_r - 1'b1;
            idle_r <= (idle_r >= CountMax) ? CountMax : idle_r + 1'b1;
            ftot_r <= sat_inc64(ftot_r);
            wr_data_r <= req_r.object_handle;
            if (has_mag && fill < FillW'(MAGAZINE_DEPTH)) begin
              fast_r <= 1'b1;
              fftot_r <= sat_inc64(fftot_r);
              state_r <= S_HEAD;
            end else begin
              n_r <= has_mag ? BatchW'(Batch) : '0;
              state_r <= S_DRAINW;
            end
          end else if (has_mag && fill != '0) begin
            fill_r[cpu] <= fill - 1'b1;
            fast_r <= 1'b1;
            fatot_r <= sat_inc64(fatot_r);
            state_r <= S_MREAD;
          end else if (list_empty) begin
            if (slabs_r >= lim_c ||
                (cend_r + (DepW+1)'(ops_c)) > (DepW+1)'(MAX_OBJECTS)) begin
              status_r <= 1'b1;
              state_r <= S_RESP;
            end else begin
              cnext_r <= cend_r;
              cend_r <= cend_r + (DepW+1)'(ops_c);
              slabs_r <= slabs_r + 1'b1;
              idle_r <= ({1'b0, idle_r} + {1'b0, ops_c} > {1'b0, CountMax}) ?
                        CountMax : idle_r + ops_c;
              state_r <= S_DECIDE;
            end
          end else begin
            refill_r <= has_mag;
            n_r <= has_mag ? refill_n : '0;
            if (pop_stack) begin
              depth_r <= depth_r - 1'b1;
              state_r <= S_LREAD;
            end else begin
              grant_r <= HandleW'(cnext_r);
              cnext_r <= cnext_r + 1'b1;
              state_r <= S_FINISH;
            end
          end
        end
        S_HEAD: begin
          // Fast free: the handle is written on top of the magazine.
          fill_r[cpu] <= fill + 1'b1;
          state_r <= S_RESP;
        end
        S_MREAD: state_r <= S_FINISH;
        S_LREAD: begin
          rd_pend_r <= 1'b1;
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          // The head read lands here; account for the granted allocation.
          if (fast_r) grant_r <= m_rdata;
          else if (rd_pend_r) grant_r <= l_rdata;
          idle_r <= (idle_r == '0) ? '0 : idle_r - 1'b1;
          live_r <= (live_r >= CountMax) ? CountMax : live_r + 1'b1;
          atot_r <= sat_inc64(atot_r);
          if (refill_r && n_r != '0) begin
            fill_r[cpu] <= fill + FillW'(n_r);
            base_r <= fill;
            cnt_r <= '0;
            state_r <= S_REFILL;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_REFILL: begin
          // Pop one list entry per cycle and write it in the next cycle.
          wr_pend_r <= (cnt_r < n_r);
          if (cnt_r < n_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (pop_stack) begin
              depth_r <= depth_r - 1'b1;
              rd_src_list_r <= 1'b1;
            end else begin
              wr_data_r <= HandleW'(cnext_r);
              cnext_r <= cnext_r + 1'b1;
              rd_src_list_r <= 1'b0;
            end
          end else begin
            state_r <= S_RESP;
          end
        end
        S_DRAINW: begin
          if (list_room) depth_r <= depth_r + 1'b1;
          if (n_r != '0) begin
            fill_r[cpu] <= fill - FillW'(n_r);
            base_r <= fill - FillW'(n_r);
            cnt_r <= '0;
            wr_pend_r <= 1'b0;
            state_r <= S_DRAIN;
          end else state_r <= S_RESP;
        end
        S_DRAIN: begin
          // Read the magazine deepest first and push each entry in the following cycle.
          if (wr_pend_r && list_room) depth_r <= depth_r + 1'b1;
          wr_pend_r <= (cnt_r < n_r);
          if (cnt_r < n_r) cnt_r <= cnt_r + 1'b1;
          else state_r <= S_RESP;
        end
        S_RESP: begin
          out_r.granted_handle   <= grant_r;
          out_r.status           <= status_r;
          out_r.from_magazine    <= fast_r;
          out_r.live_count       <= live_r;
          out_r.idle_count       <= idle_r;
          out_r.slab_count       <= slabs_r;
          out_r.alloc_total      <= atot_r;
          out_r.free_total       <= ftot_r;
          out_r.fast_alloc_total <= fatot_r;
          out_r.fast_free_total  <= fftot_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/msa_checker.sv
// Port-level checker bound to the allocator top level.
`include "magazine_slab_allocator_macros.svh"
module msa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_status,
  input logic [11:0] out_grant
);
  `MSA_ASSERT_IMP(a_fail_no_grant, clk, rst_n, out_valid && out_status, out_grant == 12'd0, "failed allocation carries a handle")
  `MSA_ASSERT_NXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MSA_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "second word taken while busy")
endmodule

bind magazine_slab_allocator msa_checker u_msa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status), .out_grant(out_ch.data.granted_handle));
